>>> src/edm_pkg.sv
// edm_pkg: shared types, constants and helpers for the edit distance matcher.
// No dependencies; used by edm_ctrl, edm_dp and edit_distance_matcher.
`default_nettype none

package edm_pkg;

  localparam int unsigned MAX_QUERY_DEF   = 16;
  localparam int unsigned QUERY_BYTES     = 16;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam logic [7:0]  CLOSE_LIMIT_RST = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LEN,
    CFG_QUERY_LOW,
    CFG_QUERY_HIGH,
    CFG_CLOSE_LIMIT
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_e;

  typedef struct packed {
    logic load;        // latch a new beat
    logic empty_done;  // empty-word beat: emit query length, reset column
    logic step;        // update one column cell
    logic finish;      // final cell of a marked last byte: emit, reset column
    logic rd_en;       // column read issue
    logic idle;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic word_end;
  } sts_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    logic [7:0] r;
    r = (v == 8'hFF) ? 8'hFF : v + 8'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/edm_ctrl.sv
// edm_ctrl: controller state machine, beat handshakes and result valid.
// Depends on edm_pkg; drives edm_dp through cmd_t, reads sts_t.
`default_nettype none

module edm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic          empty_word_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire edm_pkg::sts_t sts_i,
  output edm_pkg::cmd_t      cmd_o
);
  import edm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, acc, need_out, can_step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign acc        = in_valid_i && !in_stall_o;
  assign need_out   = sts_i.last_cell && sts_i.word_end;
  assign can_step   = !need_out || out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && !empty_word_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (can_step && sts_i.last_cell) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.idle       = 1'b1;
        cmd_o.rd_en      = 1'b1;
        cmd_o.load       = acc;
        cmd_o.empty_done = acc && empty_word_i;
      end
      ST_CALC: begin
        cmd_o.step   = can_step;
        cmd_o.rd_en  = can_step;
        cmd_o.finish = can_step && need_out;
      end
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.empty_done || cmd_o.finish) out_valid_d = 1'b1;
    else if (!out_stall_i)                out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_start_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !empty_word_i) |=> (state_q == ST_CALC))
    else $error("non-empty beat did not start a sweep");
  a_finish_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result written over a stalled result");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.empty_done || cmd_o.finish))
    else $error("result appeared without a finishing beat");
`endif

endmodule

`default_nettype wire

>>> src/edm_dp.sv
// edm_dp: datapath: config registers, valid-bit column memory, cell
// update (one per cycle when not stalled), result reg. Uses edm_pkg.
`default_nettype none

module edm_dp #(
  parameter int unsigned MAX_QUERY = edm_pkg::MAX_QUERY_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [edm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [edm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic [7:0]                        word_byte_i,
  input  wire logic                              word_end_i,
  input  wire edm_pkg::cmd_t                     cmd_i,
  output edm_pkg::sts_t                          sts_o,
  output logic [7:0]                             edit_distance_o,
  output logic                                   is_close_o
);
  import edm_pkg::*;

  localparam int unsigned DEPTH = MAX_QUERY + 1;
  localparam int unsigned CNT_W = $clog2(DEPTH);

  logic [4:0]               len_q;
  logic [8*QUERY_BYTES-1:0] query_q;
  logic [7:0]               limit_q;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_q;
  logic [7:0]       rdata_q;
  logic             rvld_q;
  logic [CNT_W-1:0] rd_addr;

  logic [CNT_W-1:0] cell_q;
  logic [7:0]       byte_q, diag_q, left_q, dist_q;
  logic             end_q;
  logic [7:0]       res_dist_q;
  logic             res_close_q;

  logic [CNT_W-1:0] clen;
  logic [7:0]       up, qbyte, mn, v, fin_dist;
  logic             first, last_cell;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      query_q <= '0;
      limit_q <= CLOSE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_QUERY_LEN:   len_q <= cfg_data_i[4:0];
        CFG_QUERY_LOW:   query_q[63:0] <= cfg_data_i;
        CFG_QUERY_HIGH:  query_q[127:64] <= cfg_data_i;
        CFG_CLOSE_LIMIT: limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign clen = (32'(len_q) > MAX_QUERY) ? CNT_W'(MAX_QUERY) : CNT_W'(len_q);

  assign last_cell = (cell_q == CNT_W'(MAX_QUERY));
  assign first     = (cell_q == '0);

  always_comb begin
    qbyte = '0;
    for (int k = 0; k < int'(QUERY_BYTES); k++) begin
      if (k < int'(MAX_QUERY) && int'(cell_q) == k + 1) qbyte = query_q[k*8 +: 8];
    end
  end

  assign up = rvld_q ? rdata_q : 8'(cell_q);

  always_comb begin
    mn = up;
    if (left_q < mn) mn = left_q;
    if (diag_q < mn) mn = diag_q;
    if (first)                   v = sat_inc(up);
    else if (qbyte == byte_q)    v = diag_q;
    else                         v = sat_inc(mn);
  end

  assign fin_dist = (cell_q == clen) ? v : dist_q;

  always_comb begin
    if (cmd_i.idle || last_cell) rd_addr = '0;
    else                         rd_addr = cell_q + CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) mem[cell_q] <= v;
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.empty_done || cmd_i.finish) vld_q <= '0;
      else if (cmd_i.step)                  vld_q[cell_q] <= 1'b1;
      if (cmd_i.rd_en) rvld_q <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
      end_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cell_q <= '0;
        end_q  <= word_end_i;
      end else if (cmd_i.step) begin
        cell_q <= last_cell ? '0 : cell_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) byte_q <= word_byte_i;
    if (cmd_i.step) begin
      diag_q <= up;
      left_q <= v;
      if (cell_q == clen) dist_q <= v;
    end
    if (cmd_i.empty_done) begin
      res_dist_q  <= 8'(clen);
      res_close_q <= (8'(clen) <= limit_q);
    end else if (cmd_i.finish) begin
      res_dist_q  <= fin_dist;
      res_close_q <= (fin_dist <= limit_q);
    end
  end

  assign sts_o.last_cell  = last_cell;
  assign sts_o.word_end   = end_q;
  assign edit_distance_o  = res_dist_q;
  assign is_close_o       = res_close_q;

`ifndef NO_ASSERTIONS
  a_cell_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (32'(cell_q) <= MAX_QUERY))
    else $error("cell index beyond column");
  a_col_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.empty_done || cmd_i.finish) |=> (vld_q == '0))
    else $error("column not reset after a result");
  a_sweep_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !last_cell) |=> (cell_q == $past(cell_q) + CNT_W'(1)))
    else $error("sweep skipped a cell");
`endif

endmodule

`default_nettype wire

>>> src/edit_distance_matcher.sv
// edit_distance_matcher: top level; Levenshtein distance to a configured query.
// Depends on edm_pkg, edm_ctrl and edm_dp.
`default_nettype none

// Streams candidate bytes, one per input beat, against a query of up to
// MAX_QUERY bytes set through the config port (write only while idle). A
// beat with word_end_i or empty_word_i produces one output beat carrying the
// distance (saturated at 255) and whether it is at most close_limit. A
// non-empty byte keeps the input stalled while all MAX_QUERY+1 column cells
// are updated through the column memory, one cell per cycle unless a stalled
// result holds the final cell, so a sweep ends before the next byte is taken.
// An empty-word beat starts no sweep. A new beat is taken only once the output
// register is free or being drained that cycle. The column resets itself
// through per-entry valid bits, so no clearing pass follows reset.
module edit_distance_matcher #(
  parameter int unsigned MAX_QUERY = edm_pkg::MAX_QUERY_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [edm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [edm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     word_byte_i,
  input  wire logic                           word_end_i,
  input  wire logic                           empty_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [7:0]                          edit_distance_o,
  output logic                                is_close_o
);
  import edm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  edm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .empty_word_i (empty_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  edm_dp #(
    .MAX_QUERY (MAX_QUERY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .word_byte_i     (word_byte_i),
    .word_end_i      (word_end_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .edit_distance_o (edit_distance_o),
    .is_close_o      (is_close_o)
  );

endmodule

`default_nettype wire

>>> tb/edit_distance_matcher_test.sv
// edit_distance_matcher_test: self-checking testbench for edit_distance_matcher.
// Predicts each distance with its own column model and checks results in order.
// Depends on edm_pkg and the edit_distance_matcher RTL.
module edit_distance_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import edm_pkg::*;

  localparam int QMAX        = MAX_QUERY_DEF;
  localparam int SETTLE_CYC  = 3 * (QMAX + 1) + 10;
  localparam int LIMIT_NS    = 4_000_000;

  typedef struct packed {
    logic [7:0] dval;
    logic       close;
  } match_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [7:0]            word_byte  = '0;
  logic                  word_end   = 1'b0;
  logic                  empty_word = 1'b0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [7:0]            dist_o;
  logic                  close_o;
  logic                  hold_on    = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int err_count   = 0;

  // predictor state
  logic [7:0] dist_col [0:QMAX];
  logic [4:0] q_len;
  logic [63:0] q_low, q_high;
  logic [7:0] close_lim;
  match_t awaited_q[$];

  edit_distance_matcher u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .word_byte_i    (word_byte),
    .word_end_i     (word_end),
    .empty_word_i   (empty_word),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .edit_distance_o(dist_o),
    .is_close_o     (close_o)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] sat_plus(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [7:0] qbyte(input int k);
    if (k < 8) return q_low[8*k +: 8];
    if (k < 16) return q_high[8*(k-8) +: 8];
    return 8'h00;
  endfunction

  function automatic void clear_col();
    for (int i = 0; i <= QMAX; i++) dist_col[i] = (i > 255) ? 8'hFF : i[7:0];
  endfunction

  task automatic predict_beat(input logic [7:0] wb, input logic last, input logic empty);
    logic [7:0] diag, up, v;
    int n;
    match_t r;
    n = (q_len > QMAX) ? QMAX : int'(q_len);
    if (empty) begin
      r.dval = n[7:0];
    end else begin
      diag = dist_col[0];
      dist_col[0] = sat_plus(dist_col[0]);
      for (int i = 1; i <= QMAX; i++) begin
        up = dist_col[i];
        if (qbyte(i - 1) == wb) begin
          v = diag;
        end else begin
          v = up;
          if (dist_col[i-1] < v) v = dist_col[i-1];
          if (diag < v) v = diag;
          v = sat_plus(v);
        end
        diag = up;
        dist_col[i] = v;
      end
      if (!last) return;
      r.dval = dist_col[n];
    end
    clear_col();
    r.close = (r.dval <= close_lim);
    awaited_q.push_back(r);
  endtask

  task automatic log_mismatch(input string what, input int want, input int got);
    err_count++;
    if (err_count <= 10) $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
  endtask

  // result checker
  always @(posedge clk) begin
    match_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_q.size() == 0) begin
        log_mismatch("unexpected result beat, distance", -1, dist_o);
      end else begin
        want = awaited_q.pop_front();
        if (dist_o !== want.dval) log_mismatch("edit_distance", want.dval, dist_o);
        if (close_o !== want.close) log_mismatch("is_close", want.close, close_o);
      end
    end
  end

  always @(posedge clk) out_stall <= hold_on || ($urandom_range(0, 99) < rx_idle_pct);

  task automatic send_beat(input logic [7:0] wb, input logic last, input logic empty);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    word_byte  <= wb;
    word_end   <= last;
    empty_word <= empty;
    do @(posedge clk); while (in_stall);
    predict_beat(wb, last, empty);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // block must be idle; writes all four registers in turn
  task automatic configure(input logic [4:0] len, input logic [63:0] low,
                           input logic [63:0] high, input logic [7:0] lim);
    logic [63:0] d;
    cfg_we  <= 1'b1;
    d = {$urandom, $urandom};
    d[4:0] = len;
    cfg_idx <= CFG_QUERY_LEN;   cfg_data <= d;    @(posedge clk);
    cfg_idx <= CFG_QUERY_LOW;   cfg_data <= low;  @(posedge clk);
    cfg_idx <= CFG_QUERY_HIGH;  cfg_data <= high; @(posedge clk);
    d = {$urandom, $urandom};
    d[7:0] = lim;
    cfg_idx <= CFG_CLOSE_LIMIT; cfg_data <= d;    @(posedge clk);
    cfg_we  <= 1'b0;
    q_len = len; q_low = low; q_high = high; close_lim = lim;
  endtask

  task automatic send_text(input string s, input logic mark_end);
    for (int k = 0; k < s.len(); k++) send_beat(s[k], mark_end && (k == s.len() - 1), 1'b0);
  endtask

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 99) < 60) return qbyte($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] alpha_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      5: return 8'($urandom_range(0, 255));
      default: return 8'h61 + 8'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [63:0] alpha_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[8*k +: 8] = alpha_byte();
    return w;
  endfunction

  task automatic random_config();
    logic [4:0] len;
    logic [7:0] lim;
    case ($urandom_range(0, 9))
      0: len = 5'd0;
      1: len = 5'd16;
      2: len = 5'($urandom_range(17, 31));
      default: len = 5'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 5))
      0: lim = 8'd0;
      1: lim = 8'd255;
      default: lim = 8'($urandom_range(0, 8));
    endcase
    if ($urandom_range(0, 3) == 0) configure(len, {$urandom, $urandom}, {$urandom, $urandom}, lim);
    else configure(len, alpha_word(), alpha_word(), lim);
  endtask

  task automatic send_word(input int len);
    for (int k = 0; k < len; k++) send_beat(pick_byte(), k == len - 1, 1'b0);
  endtask

  task automatic test_reset_values();
    send_beat(8'hA5, 1'b0, 1'b1);
    send_text("ab", 1'b1);
    send_text("hello", 1'b1);
    settle();
  endtask

  task automatic test_known_pairs();
    configure(5'd6, 64'h0000_6E65_7474_696B, 64'h0, 8'd3);
    send_text("sitting", 1'b1);
    send_text("kitten", 1'b1);
    send_beat(8'h6B, 1'b1, 1'b1);
    send_text("ki", 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    settle();
    configure(5'd16, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'd0);
    for (int k = 0; k < 16; k++) send_beat(k < 8 ? 8'hFF : 8'h00, k == 15, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    settle();
    configure(5'd31, {$urandom, $urandom}, {$urandom, $urandom}, 8'd255);
    send_beat(8'hFF, 1'b0, 1'b1);
    settle();
  endtask

  task automatic test_query_change_mid_word();
    configure(5'd3, 64'h0000_0000_0063_6261, 64'h0, 8'd1);
    send_text("ab", 1'b0);
    settle();
    configure(5'd3, 64'h0000_0000_0063_7978, 64'h0, 8'd1);
    send_text("c", 1'b1);
    settle();
  endtask

  task automatic test_saturation();
    configure(5'd0, 64'h0, 64'h0, 8'd255);
    for (int k = 0; k < 260; k++) send_beat(8'($urandom_range(0, 255)), k == 259, 1'b0);
    settle();
  endtask

  task automatic test_backpressure();
    configure(5'd4, 64'h0000_0000_6463_6261, 64'h0, 8'd2);
    fork
      begin
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    for (int w = 0; w < 30; w++) send_word($urandom_range(1, 3));
    settle();
  endtask

  task automatic test_random(input int n_items);
    int sent, r, k;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        settle();
        random_config();
      end else if (r < 12) begin
        send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        sent++;
      end else if (r < 18) begin
        k = $urandom_range(1, 6);
        for (int j = 0; j < k; j++) send_beat(pick_byte(), 1'b0, 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        sent += k + 1;
      end else begin
        k = $urandom_range(1, 20);
        send_word(k);
        sent += k;
      end
    end
    settle();
  endtask

  initial begin
    q_len = 5'd0; q_low = '0; q_high = '0; close_lim = CLOSE_LIMIT_RST;
    clear_col();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_known_pairs();
    test_query_change_mid_word();
    test_saturation();
    test_backpressure();

    tx_idle_pct = 17; rx_idle_pct = 86;
    test_random(430);
    tx_idle_pct = 86; rx_idle_pct = 17;
    test_random(430);
    tx_idle_pct = 0;  rx_idle_pct = 0;
    test_random(430);

    settle();
    if (err_count == 0 && awaited_q.size() == 0) begin
      $display("edit_distance_matcher_test: clean");
    end else begin
      $display("edit_distance_matcher_test: errors");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("edit_distance_matcher_test: errors");
    $finish;
  end

endmodule
